// ===== design/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, skipped while reset is held
`define PTW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// checked property, also during reset
`define PTW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTW_ASSERT(label, clk, rstn, prop, msg)
`define PTW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/ptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int VIRT_ADDR_BITS = 48;

    localparam logic [51:0] PHYS_MASK = (52'(1) << PHYS_ADDR_BITS) - 52'(1);
    localparam logic [51:0] OFS_4K_MASK = 52'hFFF;
    localparam logic [51:0] OFS_2M_MASK = 52'h1FFFFF;
    localparam logic [51:0] OFS_1G_MASK = 52'h3FFFFFFF;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    // input beat op codes
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_READ_DATA = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_READ_REQ = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_FAULT    = 2'd2;

    // page sizes
    localparam logic [1:0] SIZE_4K = 2'd0;
    localparam logic [1:0] SIZE_2M = 2'd1;
    localparam logic [1:0] SIZE_1G = 2'd2;

    // table levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef struct packed {
        logic        op;
        logic [47:0] virt_addr;
        logic [63:0] read_data;
    } beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [51:0] entry_addr;
        logic [51:0] phys_addr;
        logic [1:0]  page_size;
        logic [1:0]  fault_level;
    } result_t;

endpackage

`default_nettype wire

// ===== design/four_level_page_table_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// four-level x86-64 page table walker
// s_ channel: one beat per event. tuser = 0 is a translate request with the
// virtual address, tuser = 1 is an entry returned by memory for the last read.
// m_ channel: one beat per event that produces a result: a memory read
// request with the entry address, a finished translation with physical
// address and page size, or a not-present fault with its level.
// cfg_we/cfg_wdata load the root table base; write only while idle.
// a beat goes through an input register, one decode/address step and a
// result register, which loads when the input register advances with a result.
// one beat is taken every cycle while m_ drains, and a beat that produces
// no result passes even when m_ is stalled.
// requests while a walk runs and entries while idle are dropped.
// when m_tready is low the result is held and a new beat is taken only if
// the input register can drain. reset clears the walk, the root and both
// valid flags; the block accepts beats as soon as reset is released.
module four_level_page_table_walker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [51:0]  cfg_wdata,     // page_map_root
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,       // virt_addr[47:0], read_data[111:48]
    input  wire logic         s_tuser,       // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,       // entry_addr[51:0], phys_addr[103:52],
                                             // page_size[105:104], fault_level[107:106]
    output logic [1:0]        m_tuser        // kind
);

    logic [51:0]       page_map_root_reg;
    logic              in_valid_reg, in_valid_next;
    ptw_pkg::beat_t    in_beat_reg;
    logic              out_valid_reg, out_valid_next;
    ptw_pkg::result_t  out_result_reg;

    logic              has_result;
    ptw_pkg::result_t  step_result;
    logic              advance;
    logic              in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !has_result);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    ptw_walk u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .beat          (in_beat_reg),
        .page_map_root (page_map_root_reg),
        .has_result    (has_result),
        .result        (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_map_root_reg <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                page_map_root_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_beat_reg.op        <= s_tuser;
            in_beat_reg.virt_addr <= s_tdata[47:0];
            in_beat_reg.read_data <= s_tdata[111:48];
        end
        if (advance && has_result) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tdata  = {4'd0, out_result_reg.fault_level, out_result_reg.page_size,
                       out_result_reg.phys_addr, out_result_reg.entry_addr};

endmodule

`default_nettype wire

// ===== design/ptw_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptw_walk (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire ptw_pkg::beat_t    beat,
    input  wire logic [51:0]       page_map_root,
    output logic                   has_result,
    output ptw_pkg::result_t       result
);

    logic        busy_reg, busy_next;
    logic [1:0]  level_reg, level_next;
    logic [47:0] pending_virt_reg, pending_virt_next;

    logic [51:0] table_base;
    logic [47:0] virt_src;
    logic [1:0]  idx_level;
    logic [8:0]  idx;
    logic [51:0] entry_addr;
    logic [51:0] ofs_mask;
    logic [1:0]  done_size;
    logic [51:0] phys_addr;
    logic        present;
    logic        page_size_bit;

    assign present       = beat.read_data[ptw_pkg::PRESENT_BIT];
    assign page_size_bit = beat.read_data[ptw_pkg::LARGE_BIT];

    // a request reads the top table, a returned entry points at the next one
    always_comb begin
        if (beat.op == ptw_pkg::OP_TRANSLATE) begin
            table_base = page_map_root;
            virt_src   = beat.virt_addr;
            idx_level  = ptw_pkg::LVL_PML4;
        end else begin
            table_base = beat.read_data[51:0];
            virt_src   = pending_virt_reg;
            idx_level  = 2'(level_reg + 2'd1);
        end
    end

    always_comb begin
        case (idx_level)
            ptw_pkg::LVL_PML4: idx = virt_src[47:39];
            ptw_pkg::LVL_PDPT: idx = virt_src[38:30];
            ptw_pkg::LVL_PD:   idx = virt_src[29:21];
            default:           idx = virt_src[20:12];
        endcase
    end

    // base is 4 KB aligned, so the index never carries into the frame
    assign entry_addr = ((table_base & ptw_pkg::PHYS_MASK & ~ptw_pkg::OFS_4K_MASK)
                        | {40'd0, idx, 3'b000}) & ptw_pkg::PHYS_MASK;

    always_comb begin
        case (level_reg)
            ptw_pkg::LVL_PDPT: begin
                ofs_mask  = ptw_pkg::OFS_1G_MASK;
                done_size = ptw_pkg::SIZE_1G;
            end
            ptw_pkg::LVL_PD: begin
                ofs_mask  = ptw_pkg::OFS_2M_MASK;
                done_size = ptw_pkg::SIZE_2M;
            end
            default: begin
                ofs_mask  = ptw_pkg::OFS_4K_MASK;
                done_size = ptw_pkg::SIZE_4K;
            end
        endcase
    end

    assign phys_addr = ((beat.read_data[51:0] & ~ofs_mask)
                       | (52'(pending_virt_reg) & ofs_mask)) & ptw_pkg::PHYS_MASK;

    always_comb begin
        has_result        = 1'b0;
        result            = '0;
        busy_next         = busy_reg;
        level_next        = level_reg;
        pending_virt_next = pending_virt_reg;
        if (beat.op == ptw_pkg::OP_TRANSLATE) begin
            if (!busy_reg) begin
                has_result        = 1'b1;
                result.kind       = ptw_pkg::KIND_READ_REQ;
                result.entry_addr = entry_addr;
                busy_next         = 1'b1;
                level_next        = ptw_pkg::LVL_PML4;
                pending_virt_next = beat.virt_addr;
            end
        end else if (busy_reg) begin
            has_result = 1'b1;
            if (!present) begin
                result.kind        = ptw_pkg::KIND_FAULT;
                result.fault_level = level_reg;
                busy_next          = 1'b0;
                level_next         = ptw_pkg::LVL_PML4;
            end else if ((level_reg == ptw_pkg::LVL_PT)
                         || (page_size_bit && (level_reg == ptw_pkg::LVL_PDPT
                                               || level_reg == ptw_pkg::LVL_PD))) begin
                result.kind      = ptw_pkg::KIND_DONE;
                result.phys_addr = phys_addr;
                result.page_size = done_size;
                busy_next        = 1'b0;
                level_next       = ptw_pkg::LVL_PML4;
            end else begin
                result.kind       = ptw_pkg::KIND_READ_REQ;
                result.entry_addr = entry_addr;
                level_next        = idx_level;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            level_reg        <= ptw_pkg::LVL_PML4;
            pending_virt_reg <= '0;
        end else if (step_en) begin
            busy_reg         <= busy_next;
            level_reg        <= level_next;
            pending_virt_reg <= pending_virt_next;
        end
    end

`include "assert_macros.svh"

    `PTW_ASSERT(a_level_only_busy, aclk, aresetn, (level_reg != ptw_pkg::LVL_PML4) |-> busy_reg, "walk level set while idle")
    `PTW_ASSERT(a_start_walk, aclk, aresetn, (step_en && beat.op == ptw_pkg::OP_TRANSLATE && !busy_reg) |=> (busy_reg && level_reg == ptw_pkg::LVL_PML4), "request did not start a walk")
    `PTW_ASSERT(a_end_walk, aclk, aresetn, (step_en && has_result && result.kind != ptw_pkg::KIND_READ_REQ) |=> !busy_reg, "walk did not end after done or fault")
    `PTW_ASSERT_ALWAYS(a_idle_data_dropped, aclk, (beat.op == ptw_pkg::OP_READ_DATA && !busy_reg) |-> !has_result, "data beat while idle produced a result")

endmodule

`default_nettype wire

// ===== tb/sv/ptw_walk_checker.sv =====
`timescale 1ns / 1ps

module ptw_walk_checker
    import ptw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [51:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           results_pending
);

    logic [51:0] root_base;
    logic        walk_busy;
    logic [1:0]  walk_lvl;
    logic [47:0] walk_va;
    result_t     expected_results[$];

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 100)
            $display("%0t: mismatch on %s, got %h expected %h", $time, field, got, want);
        fail_count++;
    endtask

    // table frame plus the 9-bit index of the walk address at this level, times 8
    function automatic logic [51:0] entry_location(input logic [51:0] tbl_base,
                                                   input logic [1:0] lvl);
        logic [8:0] idx;
        idx = 9'(walk_va >> (39 - 9 * lvl));
        return (tbl_base & PHYS_MASK & ~OFS_4K_MASK) + {40'd0, idx, 3'b000};
    endfunction

    function automatic result_t page_done(input logic [63:0] entry, input logic [51:0] ofs,
                                          input logic [1:0] size);
        result_t r;
        r = '0;
        r.kind      = KIND_DONE;
        r.page_size = size;
        r.phys_addr = (entry[51:0] & PHYS_MASK & ~ofs) | ({4'd0, walk_va} & ofs);
        walk_busy   = 1'b0;
        walk_lvl    = LVL_PML4;
        return r;
    endfunction

    function automatic bit predict_walk_step(input logic op, input logic [47:0] va,
                                             input logic [63:0] entry, output result_t r);
        r = '0;
        if (op == OP_TRANSLATE) begin
            if (walk_busy)
                return 1'b0;
            walk_va      = va;
            walk_busy    = 1'b1;
            walk_lvl     = LVL_PML4;
            r.kind       = KIND_READ_REQ;
            r.entry_addr = entry_location(root_base, LVL_PML4);
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        if (!entry[PRESENT_BIT]) begin
            r.kind        = KIND_FAULT;
            r.fault_level = walk_lvl;
            walk_busy     = 1'b0;
            walk_lvl      = LVL_PML4;
        end else if (walk_lvl == LVL_PDPT && entry[LARGE_BIT]) begin
            r = page_done(entry, OFS_1G_MASK, SIZE_1G);
        end else if (walk_lvl == LVL_PD && entry[LARGE_BIT]) begin
            r = page_done(entry, OFS_2M_MASK, SIZE_2M);
        end else if (walk_lvl == LVL_PT) begin
            r = page_done(entry, OFS_4K_MASK, SIZE_4K);
        end else begin
            walk_lvl     = walk_lvl + 2'd1;
            r.kind       = KIND_READ_REQ;
            r.entry_addr = entry_location(entry[51:0], walk_lvl);
        end
        return 1'b1;
    endfunction

    // sampled at the falling edge, before the rising edge that takes the beat
    always @(negedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            root_base = '0;
            walk_busy = 1'b0;
            walk_lvl  = LVL_PML4;
            walk_va   = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind        = m_tuser;
                got.entry_addr  = m_tdata[51:0];
                got.phys_addr   = m_tdata[103:52];
                got.page_size   = m_tdata[105:104];
                got.fault_level = m_tdata[107:106];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat, kind", got.kind, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", got.kind, want.kind);
                    if (got.entry_addr !== want.entry_addr)
                        report_mismatch("entry_addr", got.entry_addr, want.entry_addr);
                    if (got.phys_addr !== want.phys_addr)
                        report_mismatch("phys_addr", got.phys_addr, want.phys_addr);
                    if (got.page_size !== want.page_size)
                        report_mismatch("page_size", got.page_size, want.page_size);
                    if (got.fault_level !== want.fault_level)
                        report_mismatch("fault_level", got.fault_level, want.fault_level);
                end
            end
            if (s_tvalid && s_tready) begin
                if (predict_walk_step(s_tuser, s_tdata[47:0], s_tdata[111:48], want))
                    expected_results.push_back(want);
            end
            if (cfg_we)
                root_base = cfg_wdata;
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/four_level_page_table_walker_tb.sv =====
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
    import ptw_pkg::*;

    typedef enum int {WALK_FAULT, WALK_1G, WALK_2M, WALK_4K} walk_end_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [51:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;

    int fail_count;
    int results_pending;
    int walk_beats = 0;
    bit idle_on    = 1'b0;

    four_level_page_table_walker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ptw_walk_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side back-pressure
    initial begin
        @(posedge aresetn);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input logic op, input logic [47:0] va, input logic [63:0] entry);
        bit rdy;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {entry, va};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    task automatic send_walk(input logic [47:0] va, input logic [63:0] entries[$]);
        send_beat(OP_TRANSLATE, va, rand64());
        foreach (entries[i]) begin
            // a second request in mid walk must be dropped
            if ($urandom_range(0, 15) == 0)
                send_beat(OP_TRANSLATE, 48'(rand64()), rand64());
            send_beat(OP_READ_DATA, 48'(rand64()), entries[i]);
        end
        walk_beats += 1 + entries.size();
    endtask

    task automatic random_walk();
        logic [47:0]  va;
        logic [63:0]  entries[$];
        logic [63:0]  e;
        walk_end_t    how;
        int           end_lvl;
        va = 48'(rand64());
        case ($urandom_range(0, 15))
            0:       va = '0;
            1:       va = '1;
            default: ;
        endcase
        how = walk_end_t'($urandom_range(0, 3));
        case (how)
            WALK_FAULT: end_lvl = $urandom_range(0, 3);
            WALK_1G:    end_lvl = 1;
            WALK_2M:    end_lvl = 2;
            default:    end_lvl = 3;
        endcase
        for (int lvl = 0; lvl < end_lvl; lvl++) begin
            e = rand64();
            e[PRESENT_BIT] = 1'b1;
            // page-size bit at the top level is don't-care
            if (lvl != 0)
                e[LARGE_BIT] = 1'b0;
            entries.push_back(e);
        end
        e = rand64();
        if (how == WALK_FAULT) begin
            e[PRESENT_BIT] = 1'b0;
        end else begin
            e[PRESENT_BIT] = 1'b1;
            if (end_lvl != 3)
                e[LARGE_BIT] = 1'b1;
        end
        entries.push_back(e);
        // stray return while idle
        if ($urandom_range(0, 7) == 0)
            send_beat(OP_READ_DATA, 48'(rand64()), rand64());
        send_walk(va, entries);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [51:0] root, input int n_beats, input bit calm);
        int start;
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= root;
        @(posedge aclk);
        cfg_we <= 1'b0;
        idle_on = !calm;
        start   = walk_beats;
        while (walk_beats - start < n_beats) begin
            if ($urandom_range(0, 15) == 0)
                idle_on = !calm && $urandom_range(0, 2) != 0;
            random_walk();
        end
    endtask

    initial begin
        logic [63:0] walk_q[$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        // root still at its reset value
        walk_q = {64'h1, 64'h1, 64'h1, 64'h1};
        send_walk('0, walk_q);
        walk_q = {64'hFFFF_FFFF_FFFF_FFFF, ~64'h80, ~64'h80, 64'hFFFF_FFFF_FFFF_FFFF};
        send_walk('1, walk_q);
        walk_q = {rand64() | 64'h1, 64'hFFFF_FFFF_FFFF_FFFF};
        send_walk(48'(rand64()), walk_q);
        walk_q = {64'h1, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF};
        send_walk(48'(rand64()), walk_q);
        walk_q = {64'hFFFF_FFFF_FFFF_FFFE};
        send_walk(48'(rand64()), walk_q);
        send_beat(OP_READ_DATA, '1, '1);
        send_beat(OP_TRANSLATE, 48'h8000_0000_0000, '0);
        send_beat(OP_TRANSLATE, 48'h7FFF_FFFF_FFFF, '0);
        walk_q = {64'h1, 64'h1, 64'h1, ~64'h1};
        foreach (walk_q[i])
            send_beat(OP_READ_DATA, '0, walk_q[i]);

        run_phase(52'hF_FFFF_FFFF_FFFF, 300, 1'b0);
        run_phase(52'(rand64()), 300, 1'b0);
        run_phase('0, 250, 1'b0);
        run_phase(52'(rand64()), 200, 1'b0);
        run_phase(52'(rand64()), 150, 1'b1);
        settle();

        if (fail_count == 0 && results_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
